// ===== sv/wsb_pkg.sv =====
// ----------------------------------------------------------------------------
// wsb_pkg
// Shared types and constants for the weighted-sum-plus-bias kernel.
// ----------------------------------------------------------------------------
package wsb_pkg;

    // Field widths fixed by the interface
    localparam int SAMPLE_W = 16;   // Q1.15 weight / matrix element
    localparam int WIDX_W   = 10;   // weight index on the input word
    localparam int COUNT_W  = 11;   // row / column count registers
    localparam int BIAS_W   = 32;   // Q2.30 bias
    localparam int PROD_W   = 32;   // Q2.30 product
    localparam int ACC_W    = 48;   // Q18.30 accumulator
    localparam int OIDX_W   = 10;   // index on the result word
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Input word kinds (tuser)
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_ELEM = 1'b1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_REDUCE_COLS = 3'd0,
        REG_COL_MAJOR   = 3'd1,
        REG_ROW_COUNT   = 3'd2,
        REG_COL_COUNT   = 3'd3,
        REG_BIAS        = 3'd4
    } t_cfg_reg;

    // Per-word control bits, set by the front and used by the back
    typedef struct packed {
        logic is_elem;  // matrix element (else weight load)
        logic wr_ok;    // weight load address inside the store
        logic first;    // first contribution of its sum: start from bias
        logic emit;     // completes its sum: produce a result
        logic last;     // final element of the matrix
    } t_flags;

endpackage

// ===== sv/wsb_front.sv =====
// ----------------------------------------------------------------------------
// wsb_front
// Accepts input words, walks the matrix position and tags each element with
// its accumulator slot, weight slot and start / finish flags.
// ----------------------------------------------------------------------------
module wsb_front #(
    parameter int STORE_DEPTH = 1024,
    parameter int IDX_W       = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic                          i_cmd,
    input  logic [wsb_pkg::WIDX_W-1:0]    i_weight_index,
    input  logic [wsb_pkg::SAMPLE_W-1:0]  i_sample,
    // geometry
    input  logic                          i_restart,
    input  logic                          i_reduce_cols,
    input  logic                          i_col_major,
    input  logic [IDX_W-1:0]              i_rows_m1,
    input  logic [IDX_W-1:0]              i_cols_m1,
    // queue side
    input  logic                          i_full,
    output logic                          o_push,
    output wsb_pkg::t_flags               o_flags,
    output logic [IDX_W-1:0]              o_addr_w,
    output logic [IDX_W-1:0]              o_addr_k,
    output logic [wsb_pkg::SAMPLE_W-1:0]  o_sample
);
    import wsb_pkg::*;

    logic [IDX_W-1:0] r_slow, n_slow;
    logic [IDX_W-1:0] r_fast, n_fast;
    logic [IDX_W-1:0] slow_last, fast_last, red_last;
    logic [IDX_W-1:0] row, col, k, j;
    logic             is_elem, wr_ok, fast_end, slow_end;

    assign s_axis_tready = ~i_full;
    assign o_push        = s_axis_tvalid & ~i_full;
    assign is_elem       = (i_cmd == CMD_ELEM);

    // Position decode
    always_comb begin
        slow_last = i_col_major ? i_cols_m1 : i_rows_m1;
        fast_last = i_col_major ? i_rows_m1 : i_cols_m1;
        row       = i_col_major ? r_fast : r_slow;
        col       = i_col_major ? r_slow : r_fast;
        if (i_reduce_cols) begin
            k        = row;
            j        = col;
            red_last = i_cols_m1;
        end else begin
            k        = col;
            j        = row;
            red_last = i_rows_m1;
        end
        fast_end = (r_fast == fast_last);
        slow_end = (r_slow == slow_last);
        wr_ok    = (int'(i_weight_index) < STORE_DEPTH);
    end

    // Word tagging
    always_comb begin
        o_flags.is_elem = is_elem;
        o_flags.wr_ok   = wr_ok;
        o_flags.first   = (j == '0);
        o_flags.emit    = (j == red_last);
        o_flags.last    = fast_end & slow_end;
        o_addr_w        = is_elem ? j : IDX_W'(i_weight_index);
        o_addr_k        = k;
        o_sample        = i_sample;
    end

    // Position advance
    always_comb begin
        n_slow = r_slow;
        n_fast = r_fast;
        if (i_restart) begin
            n_slow = '0;
            n_fast = '0;
        end else if (o_push && is_elem) begin
            if (fast_end) begin
                n_fast = '0;
                n_slow = slow_end ? '0 : r_slow + IDX_W'(1);
            end else begin
                n_fast = r_fast + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slow <= '0;
            r_fast <= '0;
        end else begin
            r_slow <= n_slow;
            r_fast <= n_fast;
        end
    end

endmodule

// ===== sv/wsb_queue.sv =====
// ----------------------------------------------------------------------------
// wsb_queue
// Four-entry word queue between the front and the back.
// ----------------------------------------------------------------------------
module wsb_queue #(
    parameter int WIDTH = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);
    import wsb_pkg::*;

    localparam int Depth = 4;
    localparam int PtrW  = $clog2(Depth);

    logic [WIDTH-1:0] r_mem [Depth];
    logic [PtrW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [PtrW:0]    r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == (PtrW+1)'(Depth));
    assign o_empty = (r_count == '0);
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        case ({do_push, do_pop})
            2'b10:   n_count = r_count + (PtrW+1)'(1);
            2'b01:   n_count = r_count - (PtrW+1)'(1);
            default: n_count = r_count;
        endcase
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) r_wr_ptr <= r_wr_ptr + PtrW'(1);
            if (do_pop)  r_rd_ptr <= r_rd_ptr + PtrW'(1);
            r_count <= n_count;
        end
    end

endmodule

// ===== sv/wsb_back.sv =====
// ----------------------------------------------------------------------------
// wsb_back
// Weight and accumulator stores, multiply-accumulate pipeline and result
// register. Stages: store read, multiply, accumulate / write back.
// ----------------------------------------------------------------------------
module wsb_back #(
    parameter int STORE_DEPTH = 1024,
    parameter int IDX_W       = 10
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // queue side
    input  logic                                i_empty,
    output logic                                o_pop,
    input  wsb_pkg::t_flags                     i_flags,
    input  logic [IDX_W-1:0]                    i_addr_w,
    input  logic [IDX_W-1:0]                    i_addr_k,
    input  logic [wsb_pkg::SAMPLE_W-1:0]        i_sample,
    input  logic signed [wsb_pkg::BIAS_W-1:0]   i_bias,
    // result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [wsb_pkg::OIDX_W-1:0]          o_out_index,
    output logic [wsb_pkg::ACC_W-1:0]           o_out_value,
    output logic                                m_axis_tlast
);
    import wsb_pkg::*;

    logic signed [SAMPLE_W-1:0] r_wmem [STORE_DEPTH];
    logic signed [ACC_W-1:0]    r_amem [STORE_DEPTH];

    logic                       en;
    // stage 1: store read data
    logic signed [SAMPLE_W-1:0] r_w1;
    logic signed [ACC_W-1:0]    r_a1;
    logic                       r_v1;
    t_flags                     r_f1;
    logic [IDX_W-1:0]           r_k1;
    logic signed [SAMPLE_W-1:0] r_x1;
    // stage 2: product
    logic signed [PROD_W-1:0]   r_p2;
    logic signed [ACC_W-1:0]    r_a2;
    logic                       r_v2;
    t_flags                     r_f2;
    logic [IDX_W-1:0]           r_k2;
    // last two write-backs, for forwarding
    logic                       r_h1_v, r_h2_v;
    logic [IDX_W-1:0]           r_h1_k, r_h2_k;
    logic signed [ACC_W-1:0]    r_h1_d, r_h2_d;
    // result register
    logic                       r_out_v;
    logic [OIDX_W-1:0]          r_out_idx;
    logic signed [ACC_W-1:0]    r_out_val;
    logic                       r_out_last;

    logic signed [ACC_W-1:0]    base, sum;

    // Whole pipeline moves when the result register can take a word
    assign en    = ~r_out_v | m_axis_tready;
    assign o_pop = en & ~i_empty;

    // Weight store: loads at pop, element reads at pop
    always_ff @(posedge i_clk) begin
        if (o_pop && !i_flags.is_elem && i_flags.wr_ok) begin
            r_wmem[i_addr_w] <= i_sample;
        end
        if (en) begin
            r_w1 <= r_wmem[i_addr_w];
        end
    end

    // Accumulator store: read at pop, written back from stage 2
    always_ff @(posedge i_clk) begin
        if (en && r_v2) begin
            r_amem[r_k2] <= sum;
        end
        if (en) begin
            r_a1 <= r_amem[i_addr_k];
        end
    end

    // Start value: bias, else newest pending write-back, else store
    always_comb begin
        if (r_f2.first) begin
            base = {{(ACC_W-BIAS_W){i_bias[BIAS_W-1]}}, i_bias};
        end else if (r_h1_v && (r_h1_k == r_k2)) begin
            base = r_h1_d;
        end else if (r_h2_v && (r_h2_k == r_k2)) begin
            base = r_h2_d;
        end else begin
            base = r_a2;
        end
        sum = base + {{(ACC_W-PROD_W){r_p2[PROD_W-1]}}, r_p2};
    end

    // Pipeline payload
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f1   <= i_flags;
            r_k1   <= i_addr_k;
            r_x1   <= i_sample;
            r_p2   <= PROD_W'(r_w1) * PROD_W'(r_x1);
            r_a2   <= r_a1;
            r_f2   <= r_f1;
            r_k2   <= r_k1;
            r_h1_k <= r_k2;
            r_h1_d <= sum;
            r_h2_k <= r_h1_k;
            r_h2_d <= r_h1_d;
            if (r_v2 && r_f2.emit) begin
                r_out_idx  <= OIDX_W'(r_k2);
                r_out_val  <= sum;
                r_out_last <= r_f2.last;
            end
        end
    end

    // Pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_h1_v  <= 1'b0;
            r_h2_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else if (en) begin
            r_v1    <= o_pop & i_flags.is_elem;
            r_v2    <= r_v1;
            r_h1_v  <= r_v2;
            r_h2_v  <= r_h1_v;
            r_out_v <= r_v2 & r_f2.emit;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign o_out_index   = r_out_idx;
    assign o_out_value   = r_out_val;
    assign m_axis_tlast  = r_out_last;

endmodule

// ===== sv/weighted_sum_plus_bias.sv =====
// ----------------------------------------------------------------------------
// weighted_sum_plus_bias
// Dense-layer kernel: per-row or per-column dot product with a loaded weight
// vector plus a scalar bias, on a matrix streamed in storage order.
//
//   Channel  Dir  Handshake                    Word
//   s_axis   in   s_axis_tvalid/tready         tdata: weight_index, sample;
//                                              tuser: cmd
//   m_axis   out  m_axis_tvalid/tready         tdata: out_index, out_value;
//                                              tlast: out_last
//   cfg      in   i_cfg_valid/o_cfg_ready      i_cfg_index, i_cfg_data
//
// One word per cycle in steady state while the result register is not stalled; a taken element
// passes the queue, then store read, multiply and accumulate into the result register.
// Reset clears control only; weight and accumulator stores are not cleared.
// A stalled result register stops the multiply-accumulate pipeline; the
// four-word queue keeps taking input until it fills.
// ----------------------------------------------------------------------------
module weighted_sum_plus_bias #(
    parameter int MAX_ROWS = 1024,
    parameter int MAX_COLS = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [31:0]                       s_axis_tdata,  // [9:0] weight_index, [25:10] sample
    input  logic                              s_axis_tuser,  // [0] cmd
    // result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [63:0]                       m_axis_tdata,  // [9:0] out_index, [57:10] out_value
    output logic                              m_axis_tlast,
    // configuration writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [wsb_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [wsb_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import wsb_pkg::*;

    localparam int StoreDepth = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
    localparam int IdxW       = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;
    localparam int QueueW     = $bits(t_flags) + 2 * IdxW + SAMPLE_W;

    // Configuration registers
    logic                     r_reduce_cols;
    logic                     r_col_major;
    logic [COUNT_W-1:0]       r_row_count;
    logic [COUNT_W-1:0]       r_col_count;
    logic signed [BIAS_W-1:0] r_bias;
    logic                     cfg_wr, restart;
    logic [IdxW-1:0]          rows_m1, cols_m1;

    // Front / queue / back wiring
    logic                     push, pop, full, empty;
    t_flags                   f_flags, b_flags;
    logic [IdxW-1:0]          f_addr_w, f_addr_k, b_addr_w, b_addr_k;
    logic [SAMPLE_W-1:0]      f_sample, b_sample;
    logic [QueueW-1:0]        q_in, q_out;
    logic [OIDX_W-1:0]        out_index;
    logic [ACC_W-1:0]         out_value;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid & o_cfg_ready;

    // Geometry writes restart the matrix walk; bias writes do not
    always_comb begin
        restart = 1'b0;
        if (cfg_wr) begin
            case (i_cfg_index)
                REG_REDUCE_COLS,
                REG_COL_MAJOR,
                REG_ROW_COUNT,
                REG_COL_COUNT: restart = 1'b1;
                default:       restart = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reduce_cols <= 1'b0;
            r_col_major   <= 1'b0;
            r_row_count   <= COUNT_W'(1);
            r_col_count   <= COUNT_W'(1);
            r_bias        <= '0;
        end else if (cfg_wr) begin
            case (i_cfg_index)
                REG_REDUCE_COLS: r_reduce_cols <= i_cfg_data[0];
                REG_COL_MAJOR:   r_col_major   <= i_cfg_data[0];
                REG_ROW_COUNT:   r_row_count   <= i_cfg_data[COUNT_W-1:0];
                REG_COL_COUNT:   r_col_count   <= i_cfg_data[COUNT_W-1:0];
                REG_BIAS:        r_bias        <= i_cfg_data[BIAS_W-1:0];
                default:         r_bias        <= r_bias;
            endcase
        end
    end

    // Counts minus one: zero acts as one, large values saturate
    always_comb begin
        if (r_row_count == '0) begin
            rows_m1 = '0;
        end else if (int'(r_row_count) > MAX_ROWS) begin
            rows_m1 = IdxW'(MAX_ROWS - 1);
        end else begin
            rows_m1 = IdxW'(r_row_count - COUNT_W'(1));
        end
        if (r_col_count == '0) begin
            cols_m1 = '0;
        end else if (int'(r_col_count) > MAX_COLS) begin
            cols_m1 = IdxW'(MAX_COLS - 1);
        end else begin
            cols_m1 = IdxW'(r_col_count - COUNT_W'(1));
        end
    end

    wsb_front #(
        .STORE_DEPTH (StoreDepth),
        .IDX_W       (IdxW)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .i_cmd          (s_axis_tuser),
        .i_weight_index (s_axis_tdata[WIDX_W-1:0]),
        .i_sample       (s_axis_tdata[WIDX_W+SAMPLE_W-1:WIDX_W]),
        .i_restart      (restart),
        .i_reduce_cols  (r_reduce_cols),
        .i_col_major    (r_col_major),
        .i_rows_m1      (rows_m1),
        .i_cols_m1      (cols_m1),
        .i_full         (full),
        .o_push         (push),
        .o_flags        (f_flags),
        .o_addr_w       (f_addr_w),
        .o_addr_k       (f_addr_k),
        .o_sample       (f_sample)
    );

    assign q_in = {f_flags, f_addr_w, f_addr_k, f_sample};
    assign {b_flags, b_addr_w, b_addr_k, b_sample} = q_out;

    wsb_queue #(
        .WIDTH (QueueW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_in),
        .i_pop   (pop),
        .o_data  (q_out),
        .o_full  (full),
        .o_empty (empty)
    );

    wsb_back #(
        .STORE_DEPTH (StoreDepth),
        .IDX_W       (IdxW)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (empty),
        .o_pop         (pop),
        .i_flags       (b_flags),
        .i_addr_w      (b_addr_w),
        .i_addr_k      (b_addr_k),
        .i_sample      (b_sample),
        .i_bias        (r_bias),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .o_out_index   (out_index),
        .o_out_value   (out_value),
        .m_axis_tlast  (m_axis_tlast)
    );

    assign m_axis_tdata = {{(64 - OIDX_W - ACC_W){1'b0}}, out_value, out_index};

endmodule

// ===== tb/sv/wsb_checker.sv =====
// ----------------------------------------------------------------------------
// wsb_checker
// Watches the configuration, input and result channels of the
// weighted-sum-plus-bias kernel. It keeps its own copy of the registers, the
// weight vector, the partial sums and the matrix position, and works out every
// finished sum when its matrix element is taken. Each result word is compared
// field by field with the oldest sum still due.
// ----------------------------------------------------------------------------
module wsb_checker #(
    parameter int MAX_ROWS = 1024,
    parameter int MAX_COLS = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic [31:0]                     s_axis_tdata,   // [9:0] weight_index, [25:10] sample
    input  logic                            s_axis_tuser,   // [0] cmd
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [63:0]                     m_axis_tdata,   // [9:0] out_index, [57:10] out_value
    input  logic                            m_axis_tlast,
    input  logic                            i_cfg_valid,
    input  logic                            o_cfg_ready,
    input  logic [wsb_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [wsb_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output int                              o_pending,
    output int                              o_errors,
    output int                              o_results
);
    timeunit 1ns;
    timeprecision 1ps;

    import wsb_pkg::*;

    localparam int STORE_N = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;

    // One finished sum as it should leave the block
    typedef struct packed {
        logic [OIDX_W-1:0] idx;
        logic [ACC_W-1:0]  sum;
        logic              last;
    } t_sum_word;

    t_sum_word due_sums[$];

    // Register copy
    logic               reduce_cols;
    logic               col_major;
    logic [COUNT_W-1:0] row_reg;
    logic [COUNT_W-1:0] col_reg;
    logic [BIAS_W-1:0]  bias_reg;

    // Stores and matrix position
    logic [SAMPLE_W-1:0] weight_mem [STORE_N];
    logic [ACC_W-1:0]    acc_mem    [STORE_N];
    int unsigned         slow_pos;
    int unsigned         fast_pos;

    int        err_cnt = 0;
    int        res_cnt = 0;
    t_sum_word exp_w;
    logic [ACC_W-1:0] got_sum;

    // Zero acts as one, anything above the row or column limit saturates to it
    function automatic int unsigned eff_count(input logic [COUNT_W-1:0] raw,
                                              input int unsigned lim);
        if (raw == '0)
            return 1;
        if (raw > lim)
            return lim;
        return 32'(raw);
    endfunction

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        logic geometry;
        geometry = 1'b1;
        case (idx)
            REG_REDUCE_COLS: reduce_cols = data[0];
            REG_COL_MAJOR:   col_major   = data[0];
            REG_ROW_COUNT:   row_reg     = data[COUNT_W-1:0];
            REG_COL_COUNT:   col_reg     = data[COUNT_W-1:0];
            REG_BIAS: begin
                bias_reg = data[BIAS_W-1:0];
                geometry = 1'b0;
            end
            default:         geometry = 1'b0;
        endcase
        // geometry writes restart the matrix, the bias does not
        if (geometry) begin
            slow_pos = 0;
            fast_pos = 0;
        end
    endtask

    // One multiply-accumulate; queues the sum when it is complete
    task automatic take_element(input logic [SAMPLE_W-1:0] x);
        int unsigned rows, cols, slow_n, fast_n, r, c, k, j, red_n;
        logic signed [PROD_W-1:0] prod;
        logic [ACC_W-1:0] sum;
        logic at_end;
        rows   = eff_count(row_reg, MAX_ROWS);
        cols   = eff_count(col_reg, MAX_COLS);
        slow_n = col_major ? cols : rows;
        fast_n = col_major ? rows : cols;
        if (slow_pos >= slow_n)
            slow_pos = 0;
        if (fast_pos >= fast_n)
            fast_pos = 0;

        r = col_major ? fast_pos : slow_pos;
        c = col_major ? slow_pos : fast_pos;
        k     = reduce_cols ? r : c;
        j     = reduce_cols ? c : r;
        red_n = reduce_cols ? cols : rows;

        // Q1.15 x Q1.15 -> Q2.30, first contribution starts from the bias
        prod = PROD_W'($signed(weight_mem[j])) * PROD_W'($signed(x));
        sum  = ((j == 0) ? {{(ACC_W-BIAS_W){bias_reg[BIAS_W-1]}}, bias_reg} : acc_mem[k])
             + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
        acc_mem[k] = sum;

        at_end = (slow_pos == slow_n - 1) && (fast_pos == fast_n - 1);
        fast_pos++;
        if (fast_pos >= fast_n) begin
            fast_pos = 0;
            slow_pos++;
            if (slow_pos >= slow_n)
                slow_pos = 0;
        end

        if (j == red_n - 1)
            due_sums.push_back('{idx: OIDX_W'(k), sum: sum, last: at_end});
    endtask

    // Predict on accepted input, compare on accepted results
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reduce_cols = 1'b0;
            col_major   = 1'b0;
            row_reg     = COUNT_W'(1);
            col_reg     = COUNT_W'(1);
            bias_reg    = '0;
            slow_pos    = 0;
            fast_pos    = 0;
            due_sums.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready)
                write_register(i_cfg_index, i_cfg_data);

            if (s_axis_tvalid && s_axis_tready) begin
                if (s_axis_tuser == CMD_LOAD)
                    weight_mem[s_axis_tdata[WIDX_W-1:0]] = s_axis_tdata[WIDX_W +: SAMPLE_W];
                else
                    take_element(s_axis_tdata[WIDX_W +: SAMPLE_W]);
            end

            if (m_axis_tvalid && m_axis_tready) begin
                res_cnt++;
                got_sum = m_axis_tdata[OIDX_W +: ACC_W];
                if (due_sums.size() == 0) begin
                    err_cnt++;
                    $display("%0t ns: unexpected word, expected none, got index %0d value %0d last %0b",
                             $time, m_axis_tdata[OIDX_W-1:0], $signed(got_sum), m_axis_tlast);
                end else begin
                    exp_w = due_sums.pop_front();
                    if (m_axis_tdata[OIDX_W-1:0] !== exp_w.idx) begin
                        err_cnt++;
                        $display("%0t ns: out_index expected %0d, got %0d",
                                 $time, exp_w.idx, m_axis_tdata[OIDX_W-1:0]);
                    end
                    if (got_sum !== exp_w.sum) begin
                        err_cnt++;
                        $display("%0t ns: out_value expected %0d, got %0d",
                                 $time, $signed(exp_w.sum), $signed(got_sum));
                    end
                    if (m_axis_tlast !== exp_w.last) begin
                        err_cnt++;
                        $display("%0t ns: out_last expected %0b, got %0b",
                                 $time, exp_w.last, m_axis_tlast);
                    end
                end
            end
        end
        o_pending <= due_sums.size();
        o_errors  <= err_cnt;
        o_results <= res_cnt;
    end

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the weighted-sum-plus-bias kernel. A short directed
// run covers full-scale weights, elements and biases, a zero count, an unused
// register index, weight loads and bias changes in the middle of a matrix and a
// restart by a geometry write. One full pass at the largest size follows, then
// random matrices of mostly small shapes with random idling on both streams.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import wsb_pkg::*;

    localparam int MAX_ROWS       = 1024;
    localparam int MAX_COLS       = 1024;
    localparam int N_RANDOM       = 250;
    localparam int SETTLE_CYCLES  = 10;     // margin beyond the result pipeline
    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [31:0]           s_axis_tdata  = '0;
    logic                  s_axis_tuser  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [63:0]           m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    int pending_sums;
    int fail_cnt;
    int checked_cnt;

    // Stimulus bookkeeping
    logic        idle_en    = 1'b1;
    logic [1023:0] have_weight = '0;
    logic        sh_red     = 1'b0;
    logic        sh_cm      = 1'b0;
    int unsigned sh_rows    = 1;
    int unsigned sh_cols    = 1;
    int unsigned n_words    = 0;
    int unsigned n_elems    = 0;
    int unsigned n_cfg      = 0;
    int unsigned stall_left = 0;
    int unsigned quiet_cycles = 0;

    // 12 ns clock
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    weighted_sum_plus_bias #(
        .MAX_ROWS(MAX_ROWS),
        .MAX_COLS(MAX_COLS)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    wsb_checker #(
        .MAX_ROWS(MAX_ROWS),
        .MAX_COLS(MAX_COLS)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_pending     (pending_sums),
        .o_errors      (fail_cnt),
        .o_results     (checked_cnt)
    );

    // Result side back-pressure: random bursts of stalled cycles
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (idle_en && $urandom_range(0, 5) == 0) begin
            stall_left    <= $urandom_range(0, 4);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Watchdog: too long without any word moving on any channel
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t ns: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    function automatic int unsigned clamp_count(input logic [COUNT_W-1:0] raw,
                                                input int unsigned lim);
        if (raw == '0)
            return 1;
        return (raw > lim) ? lim : 32'(raw);
    endfunction

    // Length of one sum: the weights it reads are 0 .. this - 1
    function automatic int unsigned sum_len();
        return sh_red ? sh_cols : sh_rows;
    endfunction

    function automatic logic [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic logic [BIAS_W-1:0] rand_bias();
        case ($urandom_range(0, 5))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // Send one input word, with an optional gap in front
    task automatic push_word(input logic cmd, input logic [WIDX_W-1:0] widx,
                             input logic [SAMPLE_W-1:0] smp);
        if (idle_en && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {6'd0, smp, widx};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        n_words++;
        if (cmd == CMD_LOAD)
            have_weight[widx] = 1'b1;
        else
            n_elems++;
    endtask

    // Hold the input until every due sum has come out
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_sums != 0)
            @(posedge i_clk);
    endtask

    // Idle block: nothing due and the pipeline flushed of weight loads
    task automatic settle();
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        n_cfg++;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Geometry write; unused upper data bits carry noise
    task automatic set_shape(input logic red, input logic cm,
                             input logic [COUNT_W-1:0] rows_raw,
                             input logic [COUNT_W-1:0] cols_raw);
        logic [CFG_DATA_W-1:0] d;
        settle();
        d = $urandom;
        d[0] = red;
        write_reg(REG_REDUCE_COLS, d);
        d = $urandom;
        d[0] = cm;
        write_reg(REG_COL_MAJOR, d);
        d = $urandom;
        d[COUNT_W-1:0] = rows_raw;
        write_reg(REG_ROW_COUNT, d);
        d = $urandom;
        d[COUNT_W-1:0] = cols_raw;
        write_reg(REG_COL_COUNT, d);
        sh_red  = red;
        sh_cm   = cm;
        sh_rows = clamp_count(rows_raw, MAX_ROWS);
        sh_cols = clamp_count(cols_raw, MAX_COLS);
    endtask

    task automatic set_bias(input logic [BIAS_W-1:0] b);
        settle();
        write_reg(REG_BIAS, b);
    endtask

    // Every weight a sum can read must be loaded first
    task automatic load_needed_weights();
        for (int unsigned i = 0; i < sum_len(); i++)
            if (!have_weight[i])
                push_word(CMD_LOAD, WIDX_W'(i), rand_sample());
    endtask

    // Matrix elements with weight reloads and rare full drains mixed in
    task automatic stream_elements(input int unsigned n);
        for (int unsigned i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                if ($urandom_range(0, 3) == 0)
                    push_word(CMD_LOAD, WIDX_W'($urandom_range(0, 1023)), rand_sample());
                else
                    push_word(CMD_LOAD, WIDX_W'($urandom_range(0, sum_len() - 1)),
                              rand_sample());
            end
            if ($urandom_range(0, 199) == 0)
                drain();
            push_word(CMD_ELEM, WIDX_W'($urandom), rand_sample());
        end
    endtask

    initial begin
        int unsigned base, full, nel, big, little;
        logic red, cm;
        logic [COUNT_W-1:0] rr, cr;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: 1x1 after reset, full-scale products and biases
        idle_en <= 1'b0;
        push_word(CMD_LOAD, 10'd0, 16'h8000);
        push_word(CMD_ELEM, 10'h3FF, 16'h8000);
        push_word(CMD_ELEM, 10'd0, 16'h7FFF);
        push_word(CMD_LOAD, 10'h3FF, 16'h7FFF);
        set_bias(32'h7FFF_FFFF);
        push_word(CMD_ELEM, 10'd0, 16'h8000);
        set_bias(32'h8000_0000);
        push_word(CMD_ELEM, 10'd0, 16'h8000);
        // unused register index is ignored
        settle();
        write_reg(REG_SPARE_FIRST, 32'hFFFF_FFFF);

        // zero row count acts as one; per-row sums, column-major order
        set_shape(1'b1, 1'b1, 11'd0, 11'd2);
        push_word(CMD_LOAD, 10'd1, 16'h7FFF);
        push_word(CMD_ELEM, 10'd0, 16'h7FFF);
        push_word(CMD_ELEM, 10'd0, 16'h8000);

        // 3x2 per-column sums: bias taken at each sum's first element
        set_shape(1'b0, 1'b0, 11'd3, 11'd2);
        push_word(CMD_LOAD, 10'd2, 16'h8001);
        push_word(CMD_ELEM, 10'd0, 16'h4000);
        set_bias(32'h4000_0000);
        push_word(CMD_ELEM, 10'd0, 16'hC000);
        push_word(CMD_LOAD, 10'd1, 16'h8000);     // weight change mid-matrix
        push_word(CMD_ELEM, 10'd0, 16'h7FFF);
        push_word(CMD_ELEM, 10'd0, 16'h8000);
        push_word(CMD_ELEM, 10'd0, 16'h1234);
        // restart by a geometry write with one element left
        set_shape(1'b1, 1'b0, 11'd3, 11'd2);
        push_word(CMD_ELEM, 10'd0, 16'h7FFF);
        push_word(CMD_ELEM, 10'd0, 16'h7FFF);
        drain();

        // Largest size: saturated row count, one result per row, 1024 rows
        idle_en <= 1'b1;
        set_bias(rand_bias());
        set_shape(1'b1, 1'($urandom), 11'h7FF, 11'd0);
        load_needed_weights();
        for (int i = 0; i < MAX_ROWS; i++)
            push_word(CMD_ELEM, WIDX_W'($urandom), rand_sample());

        // Random matrices, mostly small; no idling over the last fifth
        base = n_words;
        while (n_words - base < N_RANDOM) begin
            idle_en <= (n_words - base < N_RANDOM * 4 / 5) && ($urandom_range(0, 4) != 0);
            red = 1'($urandom);
            cm  = 1'($urandom);
            case ($urandom_range(0, 9))
                6, 7: begin
                    rr = COUNT_W'($urandom_range(1, 40));
                    cr = COUNT_W'($urandom_range(1, 3));
                    if ($urandom_range(0, 1) == 1) begin
                        little = 32'(rr);
                        rr = cr;
                        cr = COUNT_W'(little);
                    end
                    set_shape(red, cm, rr, cr);
                end
                8: begin
                    // one dimension at an extreme, sums run along the other
                    case ($urandom_range(0, 3))
                        0:       big = 0;
                        1:       big = 1024;
                        2:       big = 2047;
                        default: big = $urandom_range(1025, 2047);
                    endcase
                    little = $urandom_range(1, 4);
                    if ($urandom_range(0, 1) == 1)
                        set_shape(1'b1, cm, COUNT_W'(big), COUNT_W'(little));
                    else
                        set_shape(1'b0, cm, COUNT_W'(little), COUNT_W'(big));
                end
                9: ;    // keep the shape and position
                default:
                    set_shape(red, cm, COUNT_W'($urandom_range(1, 6)),
                              COUNT_W'($urandom_range(1, 6)));
            endcase
            if ($urandom_range(0, 1) == 1)
                set_bias(rand_bias());
            load_needed_weights();
            full = sh_rows * sh_cols;
            if (full <= 128 && $urandom_range(0, 3) != 0)
                nel = full * $urandom_range(1, 2);
            else
                nel = $urandom_range(1, (full < 48) ? full : 48);
            stream_elements(nel);
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Covered %0d input words (%0d matrix elements), %0d register writes,",
                 n_words, n_elems, n_cfg);
        $display("and %0d result words checked, sizes up to 1024 with idling on both sides.",
                 checked_cnt);
        if (fail_cnt == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== files.f =====
sv/wsb_pkg.sv
sv/wsb_front.sv
sv/wsb_queue.sv
sv/wsb_back.sv
sv/weighted_sum_plus_bias.sv
tb/sv/wsb_checker.sv
tb/sv/tb_top.sv
